>>> sv/bvsm_pkg.sv
package bvsm_pkg;

	// Default width of the raw ADC word.
	localparam int ADC_BITS_DEF = 12;

	// Depth of the queue between the front and the back part.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port geometry.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_ENABLE = 2'd0,
		REG_SENSE_RATIO   = 2'd1,
		REG_FULL_MV       = 2'd2,
		REG_EMPTY_MV      = 2'd3
	} reg_idx_t;

	// Conversion and filter constants.
	localparam int unsigned VREF_MV     = 3300;
	localparam int          VREF_W      = 12;
	localparam int unsigned INTERVAL_MS = 1000;
	localparam int          FRAC_BITS   = 8;
	localparam int          Q_BITS      = 24;
	localparam logic [Q_BITS-1:0] SAT_Q8 = 24'hFFFF00;

	// Percent constants.
	localparam int          PCT_W    = 7;
	localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;
	localparam logic [PCT_W-1:0] LOW_PCT  = 7'd15;
	localparam logic [PCT_W-1:0] CRIT_PCT = 7'd5;

	// Configuration register set.
	typedef struct packed {
		logic        sensor_enable;
		logic [15:0] sense_ratio;
		logic [15:0] full_millivolts;
		logic [15:0] empty_millivolts;
	} cfg_t;

endpackage

>>> sv/bvsm_in_if.sv
interface bvsm_in_if #(
	parameter int AdcBits = bvsm_pkg::ADC_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic [AdcBits-1:0] adc_raw;

	modport source (output valid, output now_ms, output adc_raw, input ready);
	modport sink (input valid, input now_ms, input adc_raw, output ready);
endinterface

>>> sv/bvsm_out_if.sv
interface bvsm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pack_millivolts;
	logic [6:0]  charge_percent;
	logic        is_low;
	logic        is_critical;
	logic        sampled;

	modport source (output valid, output pack_millivolts, output charge_percent,
		output is_low, output is_critical, output sampled, input ready);
	modport sink (input valid, input pack_millivolts, input charge_percent,
		input is_low, input is_critical, input sampled, output ready);
endinterface

>>> sv/bvsm_front.sv
module bvsm_front #(
	parameter int AdcBits = bvsm_pkg::ADC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sensor_enable,
	bvsm_in_if.sink            items,
	input  logic               push_ready,
	output logic               push_valid,
	output logic [AdcBits+1:0] push_data
);
	import bvsm_pkg::*;

	logic [31:0] last_q;
	logic        primed_q;
	logic [31:0] elapsed;
	logic        take;
	logic        first;

	// Decide at acceptance whether this word feeds the filter.
	assign elapsed = items.now_ms - last_q;
	assign take    = sensor_enable && (!primed_q || (elapsed >= 32'(INTERVAL_MS)));
	assign first   = take && !primed_q;

	assign items.ready = push_ready;
	assign push_valid  = items.valid;
	assign push_data   = {first, take, items.adc_raw};

	// Sample timer and primed flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			primed_q <= 1'b0;
		end else if (items.valid && items.ready && take) begin
			last_q   <= items.now_ms;
			primed_q <= 1'b1;
		end
	end

endmodule

>>> sv/bvsm_queue.sv
module bvsm_queue #(
	parameter int Width = 14,
	parameter int Depth = bvsm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [Width-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [Width-1:0] pop_data
);
	import bvsm_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] entry_q [Depth];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Circular buffer with separate read and write pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				entry_q[wr_q] <= push_data;
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/bvsm_back.sv
module bvsm_back #(
	parameter int AdcBits = bvsm_pkg::ADC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bvsm_pkg::cfg_t     cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [AdcBits+1:0] pop_data,
	bvsm_out_if.source         results
);
	import bvsm_pkg::*;

	localparam int ProdW = AdcBits + VREF_W;
	localparam int DenW  = AdcBits + 16;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_CHECK, ST_DIV, ST_FILT, ST_PCT, ST_PDIV, ST_OUT
	} state_t;

	state_t             state_q;
	logic               first_q;
	logic               take_q;
	logic [AdcBits-1:0] raw_q;
	logic [ProdW-1:0]   prod_q;
	logic [DenW-1:0]    den_q;
	logic [DenW-1:0]    rem_q;
	logic [Q_BITS-1:0]  quo_q;
	logic               sat_q;
	logic [4:0]         cnt_q;
	logic [Q_BITS-1:0]  filt_q;
	logic [31:0]        prem_q;
	logic [31:0]        dsr_q;
	logic [PCT_W-1:0]   pct_q;

	logic               res_valid_q;
	logic [15:0]        res_mv_q;
	logic [PCT_W-1:0]   res_pct_q;
	logic               res_low_q;
	logic               res_crit_q;
	logic               res_sampled_q;

	logic [ProdW-1:0]   prod;
	logic [DenW-1:0]    den;
	logic [DenW:0]      rem2;
	logic [DenW:0]      rem_diff;
	logic               rem_ge;
	logic [Q_BITS-1:0]  smp;
	logic [Q_BITS-1:0]  up_step;
	logic [Q_BITS-1:0]  dn_step;
	logic [15:0]        span;
	logic [Q_BITS-1:0]  empty_q8;
	logic [Q_BITS-1:0]  span_q8;
	logic [Q_BITS-1:0]  over_empty;
	logic [31:0]        pnum;
	logic               pdiv_ge;
	logic               out_free;
	logic               load_out;

	// Conversion operands: raw * Vref and (2^AdcBits - 1) * ratio.
	assign prod = ProdW'(raw_q) * ProdW'(VREF_MV);
	assign den  = {cfg.sense_ratio, AdcBits'(0)} - DenW'(cfg.sense_ratio);

	// One restoring step of the conversion division.
	assign rem2     = {rem_q, 1'b0};
	assign rem_ge   = rem2 >= {1'b0, den_q};
	assign rem_diff = rem2 - {1'b0, den_q};

	// Saturated sample and the two filter step sizes.
	assign smp     = (sat_q || (quo_q > SAT_Q8)) ? SAT_Q8 : quo_q;
	assign up_step = (smp - filt_q) >> 2;
	assign dn_step = (filt_q - smp) >> 2;

	// Percent operands; the rounding half span is added to the numerator.
	assign span       = cfg.full_millivolts - cfg.empty_millivolts;
	assign empty_q8   = {cfg.empty_millivolts, FRAC_BITS'(0)};
	assign span_q8    = {span, FRAC_BITS'(0)};
	assign over_empty = filt_q - empty_q8;
	assign pnum       = 32'(over_empty) * 32'(FULL_PCT) + 32'({span, 7'd0});
	assign pdiv_ge    = prem_q >= dsr_q;

	assign out_free  = !res_valid_q || results.ready;
	assign load_out  = (state_q == ST_OUT) && out_free;
	assign pop_ready = (state_q == ST_IDLE);

	assign results.valid           = res_valid_q;
	assign results.pack_millivolts = res_mv_q;
	assign results.charge_percent  = res_pct_q;
	assign results.is_low          = res_low_q;
	assign results.is_critical     = res_crit_q;
	assign results.sampled         = res_sampled_q;

	// Sequencer for conversion, filter update, percent division and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			first_q       <= 1'b0;
			take_q        <= 1'b0;
			raw_q         <= '0;
			prod_q        <= '0;
			den_q         <= '0;
			rem_q         <= '0;
			quo_q         <= '0;
			sat_q         <= 1'b0;
			cnt_q         <= '0;
			filt_q        <= '0;
			prem_q        <= '0;
			dsr_q         <= '0;
			pct_q         <= '0;
			res_valid_q   <= 1'b0;
			res_mv_q      <= '0;
			res_pct_q     <= '0;
			res_low_q     <= 1'b0;
			res_crit_q    <= 1'b0;
			res_sampled_q <= 1'b0;
		end else begin
			// A new result replaces one that is taken in the same cycle.
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						first_q <= pop_data[AdcBits+1];
						take_q  <= pop_data[AdcBits];
						raw_q   <= pop_data[AdcBits-1:0];
						state_q <= pop_data[AdcBits] ? ST_MUL : ST_PCT;
					end
				end
				ST_MUL: begin
					prod_q  <= prod;
					den_q   <= den;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// Quotient of 2^24 or more saturates; this also covers a zero ratio.
					sat_q   <= DenW'(prod_q) >= den_q;
					rem_q   <= DenW'(prod_q);
					quo_q   <= '0;
					cnt_q   <= 5'(Q_BITS - 1);
					state_q <= (DenW'(prod_q) >= den_q) ? ST_FILT : ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_ge ? rem_diff[DenW-1:0] : rem2[DenW-1:0];
					quo_q <= {quo_q[Q_BITS-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (first_q) begin
						filt_q <= smp;
					end else if (smp >= filt_q) begin
						filt_q <= filt_q + up_step;
					end else begin
						filt_q <= filt_q - dn_step;
					end
					state_q <= ST_PCT;
				end
				ST_PCT: begin
					if ((cfg.full_millivolts <= cfg.empty_millivolts) || (filt_q <= empty_q8)) begin
						pct_q   <= '0;
						state_q <= ST_OUT;
					end else if (over_empty >= span_q8) begin
						pct_q   <= FULL_PCT;
						state_q <= ST_OUT;
					end else begin
						prem_q  <= pnum;
						dsr_q   <= 32'({span, 14'd0});
						pct_q   <= '0;
						cnt_q   <= 5'(PCT_W - 1);
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (pdiv_ge) begin
						prem_q <= prem_q - dsr_q;
					end
					dsr_q <= dsr_q >> 1;
					pct_q <= {pct_q[PCT_W-2:0], pdiv_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						res_mv_q      <= filt_q[Q_BITS-1:FRAC_BITS];
						res_pct_q     <= pct_q;
						res_low_q     <= pct_q <= LOW_PCT;
						res_crit_q    <= pct_q <= CRIT_PCT;
						res_sampled_q <= take_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/battery_voltage_soc_monitor_top.sv
// A word that does not sample goes from acceptance straight to the percent step and the
// result register (the percent division is skipped at 0 or 100 percent); one that samples
// first passes the 24-step conversion division, unless it saturates, and the filter update;
// the 7-step percent division in the back sequencer follows when it is needed.
// The back sequencer takes a new word only once the result of the last one is registered
// and holds while a result waits; the front takes words into a short queue meanwhile.
// Reset: arst_n clears the filter, sample timer and queue at once; no clearing pass.
module battery_voltage_soc_monitor_top #(
	parameter int AdcBits    = bvsm_pkg::ADC_BITS_DEF,
	parameter int QueueDepth = bvsm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bvsm_in_if.sink                         items,
	bvsm_out_if.source                      results,
	input  logic                            cfg_we,
	input  logic [bvsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bvsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bvsm_pkg::*;

	cfg_t               cfg_q;
	logic               push_valid;
	logic               push_ready;
	logic [AdcBits+1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [AdcBits+1:0] pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enable    <= 1'b0;
			cfg_q.sense_ratio      <= 16'd11495;
			cfg_q.full_millivolts  <= 16'd12600;
			cfg_q.empty_millivolts <= 16'd9000;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SENSOR_ENABLE: cfg_q.sensor_enable    <= cfg_wdata[0];
				REG_SENSE_RATIO:   cfg_q.sense_ratio      <= cfg_wdata;
				REG_FULL_MV:       cfg_q.full_millivolts  <= cfg_wdata;
				REG_EMPTY_MV:      cfg_q.empty_millivolts <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Front: accepts words and decides which ones sample.
	bvsm_front #(.AdcBits(AdcBits)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sensor_enable (cfg_q.sensor_enable),
		.items         (items),
		.push_ready    (push_ready),
		.push_valid    (push_valid),
		.push_data     (push_data)
	);

	// Queue between front and back.
	bvsm_queue #(.Width(AdcBits + 2), .Depth(QueueDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back: conversion, filter and percent.
	bvsm_back #(.AdcBits(AdcBits)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

endmodule

>>> tb/sv/testbench.sv
module testbench;
	import bvsm_pkg::*;

	localparam int ADC_W       = ADC_BITS_DEF;
	localparam int SETTLE      = 40;
	localparam int QUIET_LIMIT = 4000;
	localparam int PRINT_CAP   = 100;

	typedef struct packed {
		logic [31:0]      tick;
		logic [ADC_W-1:0] raw;
	} sense_word_t;

	typedef struct packed {
		logic [15:0] pack_mv;
		logic [6:0]  percent;
		logic        low;
		logic        critical;
		logic        sampled;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             drv_valid = 1'b0;
	logic [31:0]      drv_tick = '0;
	logic [ADC_W-1:0] drv_raw = '0;
	logic             rcv_ready = 1'b0;

	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	bvsm_in_if #(.AdcBits(ADC_W)) sense_ch ();
	bvsm_out_if                   reading_ch ();

	assign sense_ch.valid   = drv_valid;
	assign sense_ch.now_ms  = drv_tick;
	assign sense_ch.adc_raw = drv_raw;
	assign reading_ch.ready = rcv_ready;

	battery_voltage_soc_monitor_top #(.AdcBits(ADC_W)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (sense_ch),
		.results   (reading_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the register set and of the filter state.
	logic        reg_enable   = 1'b0;
	logic [15:0] reg_divider  = 16'd11495;
	logic [15:0] reg_full_mv  = 16'd12600;
	logic [15:0] reg_empty_mv = 16'd9000;
	logic [23:0] soc_filt_q8  = '0;
	logic [31:0] soc_last_ms  = '0;
	logic        soc_primed   = 1'b0;

	sense_word_t pending_words[$];
	reading_t    expected_readings[$];
	int          pushed_count = 0;
	int          accepted_count = 0;
	int          reading_count = 0;
	int          error_count = 0;
	int          quiet_cycles = 0;
	logic        word_taken = 1'b0;

	// Raw count to pack millivolts in 16.8 units, saturated.
	function automatic logic [23:0] convert_q8(logic [ADC_W-1:0] raw);
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		den = ((64'd1 << ADC_W) - 64'd1) * {48'd0, reg_divider};
		num = ({52'd0, raw} * {32'd0, VREF_MV}) << 24;
		if (den == 64'd0)
			return SAT_Q8;
		q = num / den;
		if (q > {40'd0, SAT_Q8})
			return SAT_Q8;
		return q[23:0];
	endfunction

	// Charge percent of a 16.8 voltage, rounded to nearest and clamped.
	function automatic logic [6:0] percent_of_q8(logic [23:0] v);
		logic [63:0] empty_q8;
		logic [63:0] span;
		logic [63:0] num;
		logic [63:0] p;
		if (reg_full_mv <= reg_empty_mv)
			return 7'd0;
		empty_q8 = {48'd0, reg_empty_mv} << 8;
		if ({40'd0, v} <= empty_q8)
			return 7'd0;
		span = {48'd0, reg_full_mv - reg_empty_mv} << 8;
		num = ({40'd0, v} - empty_q8) * 64'd100;
		if (num >= span * 64'd100)
			return FULL_PCT;
		p = (64'd2 * num + span) / (64'd2 * span);
		return p[6:0];
	endfunction

	// Advances the filter for one accepted word and returns the reading it yields.
	function automatic reading_t predict_soc(logic [31:0] tick, logic [ADC_W-1:0] raw);
		reading_t    r;
		logic [23:0] s;
		logic [31:0] dt;
		logic [6:0]  pct;
		r.sampled = 1'b0;
		dt = tick - soc_last_ms;
		if (reg_enable && (!soc_primed || dt >= INTERVAL_MS)) begin
			s = convert_q8(raw);
			soc_last_ms = tick;
			if (!soc_primed) begin
				soc_filt_q8 = s;
				soc_primed = 1'b1;
			end else if (s >= soc_filt_q8) begin
				soc_filt_q8 = soc_filt_q8 + ((s - soc_filt_q8) >> 2);
			end else begin
				soc_filt_q8 = soc_filt_q8 - ((soc_filt_q8 - s) >> 2);
			end
			r.sampled = 1'b1;
		end
		pct = percent_of_q8(soc_filt_q8);
		r.pack_mv = soc_filt_q8[23:8];
		r.percent = pct;
		r.low = (pct <= LOW_PCT);
		r.critical = (pct <= CRIT_PCT);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < PRINT_CAP)
			$display("mismatch on reading %0d: %s got %0d expected %0d",
				reading_count, what, got, want);
		error_count++;
	endtask

	// Word driver: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		sense_word_t w;
		logic        v;
		if (arst_n && (!drv_valid || word_taken)) begin
			v = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				v = 1'b1;
				drv_tick <= w.tick;
				drv_raw <= w.raw;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end
			end
			drv_valid <= v;
		end
	end

	// Reading receiver: ready follows a rotating pattern that is replaced now and then.
	logic [15:0] ready_pattern = 16'hFFFF;
	int          pattern_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(20, 200);
				if ($urandom_range(0, 3) == 0)
					ready_pattern = 16'hFFFF;
				else
					ready_pattern = 16'($urandom);
				if (ready_pattern == 16'h0000)
					ready_pattern = 16'h0001;
			end
			pattern_left--;
			rcv_ready <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
	end

	// Monitor: predicts on every accepted word and checks every accepted reading.
	always @(posedge clk) begin
		reading_t want;
		logic     fired_in;
		logic     fired_out;
		if (arst_n) begin
			fired_in = sense_ch.valid && sense_ch.ready;
			fired_out = reading_ch.valid && reading_ch.ready;
			word_taken <= fired_in;
			if (fired_in) begin
				expected_readings.push_back(predict_soc(sense_ch.now_ms, sense_ch.adc_raw));
				accepted_count++;
			end
			if (fired_out) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected reading, pack_millivolts",
						int'(reading_ch.pack_millivolts), -1);
				end else begin
					want = expected_readings.pop_front();
					if (reading_ch.pack_millivolts !== want.pack_mv)
						report_mismatch("pack_millivolts", int'(reading_ch.pack_millivolts),
							int'(want.pack_mv));
					if (reading_ch.charge_percent !== want.percent)
						report_mismatch("charge_percent", int'(reading_ch.charge_percent),
							int'(want.percent));
					if (reading_ch.is_low !== want.low)
						report_mismatch("is_low", int'(reading_ch.is_low), int'(want.low));
					if (reading_ch.is_critical !== want.critical)
						report_mismatch("is_critical", int'(reading_ch.is_critical),
							int'(want.critical));
					if (reading_ch.sampled !== want.sampled)
						report_mismatch("sampled", int'(reading_ch.sampled),
							int'(want.sampled));
				end
				reading_count++;
			end
			if (fired_in || fired_out)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end else begin
			word_taken <= 1'b0;
		end
	end

	// The run is abandoned when nothing moves for too long.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic add_word(logic [31:0] tick, logic [ADC_W-1:0] raw);
		sense_word_t w;
		w.tick = tick;
		w.raw = raw;
		pending_words.push_back(w);
		pushed_count++;
	endtask

	// Waits until every word has been accepted and every reading checked.
	task automatic wait_drained();
		while (accepted_count != pushed_count || expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SENSOR_ENABLE: reg_enable = val[0];
			REG_SENSE_RATIO:   reg_divider = val;
			REG_FULL_MV:       reg_full_mv = val;
			REG_EMPTY_MV:      reg_empty_mv = val;
			default: ;
		endcase
	endtask

	// One register setting per random phase; the first few are fixed extremes.
	task automatic random_setting(int phase);
		logic [15:0] en_word;
		logic [15:0] div;
		logic [15:0] full;
		logic [15:0] empty;
		int          pick;
		en_word = 16'($urandom);
		en_word[0] = (phase < 3) ? 1'b1 : ($urandom_range(0, 9) != 0);
		pick = $urandom_range(0, 99);
		div = 16'($urandom_range(8000, 24000));
		empty = 16'($urandom_range(6000, 11000));
		full = 16'(empty + $urandom_range(1, 8000));
		case (phase)
			0: begin
				div = 16'hFFFF;
				full = 16'hFFFF;
				empty = 16'h0000;
			end
			1: div = 16'd1;
			2: full = empty;
			default: begin
				if (pick < 8)
					div = 16'($urandom);
				else if (pick < 12)
					div = 16'd0;
				else if (pick < 20)
					full = 16'(empty - $urandom_range(0, 3000));
				else if (pick < 28) begin
					full = 16'($urandom);
					empty = 16'($urandom);
				end
			end
		endcase
		write_reg(REG_SENSOR_ENABLE, en_word);
		write_reg(REG_SENSE_RATIO, div);
		write_reg(REG_FULL_MV, full);
		write_reg(REG_EMPTY_MV, empty);
	endtask

	// A run of ticks that mostly step past the sampling interval, with noise mixed in.
	task automatic add_random_run(int n);
		logic [31:0] tick;
		int          raw;
		int          pick;
		if ($urandom_range(0, 2) == 0)
			tick = 32'hFFFF_FFFF - $urandom_range(0, 30000);
		else
			tick = $urandom;
		raw = $urandom_range(0, 4095);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				tick = tick + $urandom_range(1000, 1600);
			else if (pick < 80)
				tick = tick + $urandom_range(0, 999);
			else if (pick < 90)
				tick = tick + $urandom_range(990, 1010);
			else if (pick < 95)
				tick = tick + $urandom;
			else
				tick = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				raw = ($urandom_range(0, 1) == 0) ? 0 : 4095;
			else if (pick < 50)
				raw = $urandom_range(0, 4095);
			else begin
				raw = raw + $urandom_range(0, 200) - 100;
				if (raw < 0)
					raw = 0;
				if (raw > 4095)
					raw = 4095;
			end
			add_word(tick, raw[ADC_W-1:0]);
		end
	endtask

	// Stimulus: directed cases first, then random phases under changing settings.
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Sensor disabled after reset: nothing samples and 0 mV is reported.
		add_word(32'h0000_0000, 12'hFFF);
		add_word(32'hFFFF_FFFF, 12'h000);
		add_word(32'h5555_5555, 12'hAAA);
		wait_drained();

		// First word primes, then the interval boundary and a wrapping tick.
		write_reg(REG_SENSOR_ENABLE, 16'd1);
		add_word(32'd5, 12'hFFF);
		add_word(32'd1004, 12'h000);
		add_word(32'd1005, 12'h000);
		add_word(32'd1005, 12'hFFF);
		add_word(32'hFFFF_FE00, 12'h800);
		add_word(32'h0000_01E8, 12'h800);
		wait_drained();

		// Smallest divider ratio with the smallest nonzero raw word, then a zero ratio that saturates the sample.
		write_reg(REG_SENSE_RATIO, 16'd1);
		add_word(32'h0000_1000, 12'h001);
		wait_drained();
		write_reg(REG_SENSE_RATIO, 16'd0);
		add_word(32'h0000_2000, 12'hFFF);
		wait_drained();

		// Widest span with the largest ratio.
		write_reg(REG_SENSE_RATIO, 16'hFFFF);
		write_reg(REG_FULL_MV, 16'hFFFF);
		write_reg(REG_EMPTY_MV, 16'h0000);
		add_word(32'h0000_3000, 12'hFFF);
		add_word(32'h0000_4000, 12'h000);
		wait_drained();

		// Full not above empty always reports zero percent.
		write_reg(REG_FULL_MV, 16'd5000);
		write_reg(REG_EMPTY_MV, 16'd5000);
		add_word(32'h0000_5000, 12'd2000);
		wait_drained();
		write_reg(REG_FULL_MV, 16'd4000);
		add_word(32'h0000_6000, 12'd2000);
		wait_drained();
		write_reg(REG_FULL_MV, 16'h0000);
		write_reg(REG_EMPTY_MV, 16'hFFFF);
		add_word(32'h0000_7000, 12'd3000);
		wait_drained();

		// Disable and re-enable keep the filter; then walk down to low and critical.
		write_reg(REG_SENSE_RATIO, 16'd11495);
		write_reg(REG_FULL_MV, 16'd12600);
		write_reg(REG_EMPTY_MV, 16'd9000);
		write_reg(REG_SENSOR_ENABLE, 16'hFFFE);
		add_word(32'h0000_8000, 12'hFFF);
		wait_drained();
		write_reg(REG_SENSOR_ENABLE, 16'd1);
		for (int k = 0; k < 4; k++)
			add_word(32'h0000_9000 + 32'd1000 * k, 12'd2067);
		for (int k = 0; k < 3; k++)
			add_word(32'h0001_0000 + 32'd1200 * k, 12'd0);
		wait_drained();

		for (int p = 0; p < 12; p++) begin
			random_setting(p);
			add_random_run(120);
			wait_drained();
		end

		if (error_count == 0 && expected_readings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/bvsm_pkg.sv
sv/bvsm_in_if.sv
sv/bvsm_out_if.sv
sv/bvsm_front.sv
sv/bvsm_queue.sv
sv/bvsm_back.sv
sv/battery_voltage_soc_monitor_top.sv
tb/sv/testbench.sv
